// ===== rtl/cpseg_pkg.sv =====
// shared types and constants for the closest-point-on-segment unit
// no dependencies
package cpseg_pkg;

    localparam int unsigned FRAC_BITS  = 16;   // q16.16 coordinates (result is format free)
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned DIFF_W     = COORD_W + 1;
    localparam int unsigned PROD_W     = 2 * DIFF_W;
    localparam int unsigned NUM_W      = PROD_W + 1;
    localparam int unsigned DEN_W      = PROD_W;
    localparam int unsigned QUO_W      = COORD_W + 1;
    localparam int unsigned DIV_CELLS  = COORD_W;
    localparam int unsigned MUL_W      = QUO_W + COORD_W;
    localparam int unsigned PIPE_DEPTH = 4 + DIV_CELLS + 2;

    // configuration register index
    typedef enum logic [2:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } t_reg_idx;

    // region code of a result
    typedef enum logic [1:0] {
        RGN_INTERIOR = 2'd0,
        RGN_START    = 2'd1,
        RGN_END      = 2'd2,
        RGN_DEGEN    = 2'd3
    } t_region;

    // segment values derived from the configuration
    typedef struct packed {
        logic signed [2:0][DIFF_W-1:0] d;
        logic [2:0][COORD_W-1:0]       mag;
        logic [2:0]                    neg;
        logic                          deg;
    } t_seg;

    // one beat travelling through the divider chain
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        t_region          region;
    } t_div;

endpackage

// ===== rtl/closest_point_on_segment_3d_unit.sv =====
// closest point on a fixed 3d segment, top level
// depends on cpseg_pkg, cpseg_front, cpseg_div_cell, cpseg_back
//
// usage:
//  - the segment start and end are written through the config port
//    (i_cfg_we, i_cfg_idx, i_cfg_data); indexes 0..2 start xyz, 3..5 end xyz,
//    other indexes are ignored; write only while no beat is in flight
//  - query beats enter on i_in_valid/o_in_ready, one point per beat
//  - each query gives exactly one result beat on o_out_valid/i_out_ready:
//    the nearest point and its region code
//  - throughput one beat per cycle while the output is not stalled; the path is four front
//    stages, 32 divider cells (one quotient bit each) and two back stages
//  - every stage holds its beat when its successor is stalled, so empty
//    stages keep filling while a result waits at the output register
//  - reset (synchronous, active low) clears all valid bits and the segment
//    registers to zero
module closest_point_on_segment_3d_unit import cpseg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [COORD_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [COORD_W-1:0] i_query_x,
    input  logic signed [COORD_W-1:0] i_query_y,
    input  logic signed [COORD_W-1:0] i_query_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [COORD_W-1:0] o_near_x,
    output logic signed [COORD_W-1:0] o_near_y,
    output logic signed [COORD_W-1:0] o_near_z,
    output logic [1:0]          o_region
);

    logic [2:0][COORD_W-1:0] r_start;
    logic [2:0][COORD_W-1:0] r_end;
    t_seg                    r_seg;
    t_seg                    n_seg;
    logic [2:0][COORD_W-1:0] query;
    logic [2:0][COORD_W-1:0] near;
    t_region                 region;

    logic [DIV_CELLS:0] ch_v;
    logic [DIV_CELLS:0] ch_r;
    t_div               ch_d [DIV_CELLS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_X: r_start[0] <= i_cfg_data;
                REG_START_Y: r_start[1] <= i_cfg_data;
                REG_START_Z: r_start[2] <= i_cfg_data;
                REG_END_X:   r_end[0]   <= i_cfg_data;
                REG_END_Y:   r_end[1]   <= i_cfg_data;
                REG_END_Z:   r_end[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // direction vector, its magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_seg.d[i]   = $signed({r_end[i][COORD_W-1], r_end[i]})
                         - $signed({r_start[i][COORD_W-1], r_start[i]});
            n_seg.neg[i] = n_seg.d[i][DIFF_W-1];
            n_seg.mag[i] = n_seg.neg[i] ? COORD_W'(-n_seg.d[i]) : COORD_W'(n_seg.d[i]);
        end
        n_seg.deg = (n_seg.d == '0);
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign query = {i_query_z, i_query_y, i_query_x};

    cpseg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_seg   (r_seg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_query (query),
        .o_valid (ch_v[0]),
        .i_ready (ch_r[0]),
        .o_div   (ch_d[0])
    );

    // divider chain
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        cpseg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ch_v[g]),
            .o_ready (ch_r[g]),
            .i_div   (ch_d[g]),
            .o_valid (ch_v[g+1]),
            .i_ready (ch_r[g+1]),
            .o_div   (ch_d[g+1])
        );
    end

    cpseg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_end    (r_end),
        .i_seg    (r_seg),
        .i_valid  (ch_v[DIV_CELLS]),
        .o_ready  (ch_r[DIV_CELLS]),
        .i_div    (ch_d[DIV_CELLS]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_near   (near),
        .o_region (region)
    );

    assign o_near_x = near[0];
    assign o_near_y = near[1];
    assign o_near_z = near[2];
    assign o_region = region;

endmodule

// ===== rtl/cpseg_front.sv =====
// front end: offsets, dot products, sums and classification (four stages)
// depends on cpseg_pkg
module cpseg_front import cpseg_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [2:0][COORD_W-1:0]   i_start,
    input  t_seg                      i_seg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0][COORD_W-1:0]   i_query,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_div                      o_div
);

    logic [3:0] r_v;
    logic [3:0] en;
    logic signed [2:0][DIFF_W-1:0] r_w;
    logic signed [2:0][PROD_W-1:0] r_pn;
    logic [2:0][PROD_W-1:0]        r_pd;
    logic                          r_deg2, r_deg3;
    logic signed [NUM_W-1:0]       r_num;
    logic [DEN_W-1:0]              r_den;
    t_div                          r_out;
    logic signed [NUM_W-1:0]       n_num;
    logic [DEN_W-1:0]              n_den;
    logic                          num_gt, num_eq;
    t_region                       n_rgn;

    // stall chain: a stage moves when it is empty or its successor moves
    assign en[3]   = !r_v[3] || i_ready;
    assign en[2]   = !r_v[2] || en[3];
    assign en[1]   = !r_v[1] || en[2];
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];
    assign o_valid = r_v[3];
    assign o_div   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    // sums of the three products
    always_comb begin
        n_num = '0;
        n_den = '0;
        for (int i = 0; i < 3; i++) begin
            n_num = n_num + NUM_W'($signed(r_pn[i]));
            n_den = n_den + r_pd[i];
        end
    end

    // classification and first quotient bit
    assign num_eq = (r_num == $signed({1'b0, r_den}));
    assign num_gt = !r_num[NUM_W-1] && (r_num[NUM_W-2:0] > r_den);
    always_comb begin
        if (r_deg3)                n_rgn = RGN_DEGEN;
        else if (r_num[NUM_W-1])   n_rgn = RGN_START;
        else if (num_gt)           n_rgn = RGN_END;
        else                       n_rgn = RGN_INTERIOR;
    end

    always_ff @(posedge i_clk) begin
        // stage 1: query minus start
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= $signed({i_query[i][COORD_W-1], i_query[i]})
                        - $signed({i_start[i][COORD_W-1], i_start[i]});
            end
        end
        // stage 2: products
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_pn[i] <= PROD_W'($signed(r_w[i])) * PROD_W'($signed(i_seg.d[i]));
                r_pd[i] <= PROD_W'(i_seg.mag[i]) * PROD_W'(i_seg.mag[i]);
            end
            r_deg2 <= i_seg.deg;
        end
        // stage 3: dot products
        if (en[2]) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_deg3 <= r_deg2;
        end
        // stage 4: region and first divide step
        if (en[3]) begin
            r_out.region <= n_rgn;
            r_out.den    <= r_den;
            r_out.rem    <= num_eq ? '0 : r_num[DEN_W-1:0];
            r_out.quo    <= QUO_W'(num_eq);
        end
    end

endmodule

// ===== rtl/cpseg_div_cell.sv =====
// one restoring divide cell: shift, compare, subtract, one quotient bit
// depends on cpseg_pkg
module cpseg_div_cell import cpseg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_div,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    logic             r_v;
    t_div             r_div;
    logic [DEN_W:0]   shl;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_div   = r_div;

    // trial subtract of the shifted remainder
    assign shl  = {i_div.rem, 1'b0};
    assign ge   = shl >= {1'b0, i_div.den};
    assign diff = shl - {1'b0, i_div.den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_div.rem    <= ge ? diff[DEN_W-1:0] : shl[DEN_W-1:0];
            r_div.den    <= i_div.den;
            r_div.quo    <= {i_div.quo[QUO_W-2:0], ge};
            r_div.region <= i_div.region;
        end
    end

endmodule

// ===== rtl/cpseg_back.sv =====
// back end: scale the direction by the quotient, round, add start, pick endpoint
// depends on cpseg_pkg
module cpseg_back import cpseg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [2:0][COORD_W-1:0] i_start,
    input  logic [2:0][COORD_W-1:0] i_end,
    input  t_seg                    i_seg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_div                    i_div,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2:0][COORD_W-1:0] o_near,
    output t_region                 o_region
);

    logic [1:0]                    r_v;
    logic [1:0]                    en;
    logic [2:0][MUL_W-1:0]         r_m;
    t_region                       r_rgn;
    logic [2:0][COORD_W-1:0]       r_near;
    t_region                       r_rgn_out;
    logic [2:0][COORD_W-1:0]       n_near;
    logic [MUL_W-1:0]              rnd;
    logic signed [COORD_W+2:0]     off;
    logic signed [COORD_W+2:0]     sum;

    assign en[1]    = !r_v[1] || i_ready;
    assign en[0]    = !r_v[0] || en[1];
    assign o_ready  = en[0];
    assign o_valid  = r_v[1];
    assign o_near   = r_near;
    assign o_region = r_rgn_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    // round half away from zero, apply sign, add start, saturate
    always_comb begin
        rnd = '0;
        off = '0;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            rnd = r_m[i] + (MUL_W'(1) << (COORD_W - 1));
            off = $signed({2'b00, rnd[MUL_W-1:COORD_W]});
            if (i_seg.neg[i]) off = -off;
            sum = $signed({{3{i_start[i][COORD_W-1]}}, i_start[i]}) + off;
            unique case (r_rgn)
                RGN_INTERIOR: begin
                    if (sum > $signed({3'b000, {(COORD_W-1){1'b1}}}))
                        n_near[i] = {1'b0, {(COORD_W-1){1'b1}}};
                    else if (sum < -$signed({3'b001, {(COORD_W-1){1'b0}}}))
                        n_near[i] = {1'b1, {(COORD_W-1){1'b0}}};
                    else
                        n_near[i] = sum[COORD_W-1:0];
                end
                RGN_END:     n_near[i] = i_end[i];
                default:     n_near[i] = i_start[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: quotient times direction magnitude
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= MUL_W'(i_div.quo) * MUL_W'(i_seg.mag[i]);
            end
            r_rgn <= i_div.region;
        end
        // stage 2: output register
        if (en[1]) begin
            r_near    <= n_near;
            r_rgn_out <= r_rgn;
        end
    end

endmodule

// ===== rtl/cpseg_checker.sv =====
// port-level checks for the closest-point unit, bound to the top level
// depends on cpseg_pkg
module cpseg_checker import cpseg_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [COORD_W-1:0]  o_near_x,
    input logic [1:0]          o_region
);

    logic [$clog2(PIPE_DEPTH+2)-1:0] r_cnt;
    logic                            in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // beats in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + ($bits(r_cnt))'(in_acc) - ($bits(r_cnt))'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_near_x)
        && $stable(o_region))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result beat without a query in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ($bits(r_cnt))'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

endmodule

bind closest_point_on_segment_3d_unit cpseg_checker u_cpseg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_near_x    (o_near_x),
    .o_region    (o_region)
);
